@@ rtl/ssrc_pkg.sv @@
// shared types, constants and level tables for the single switch ramp controller
// no dependencies

package ssrc_pkg;

	localparam int unsigned NUM_LEVELS_DEF = 64;
	localparam int unsigned LVL_W          = 6;
	localparam int unsigned CNT_W          = 8;
	localparam int unsigned HIST_W         = 4;
	localparam int unsigned COLOR_W        = 2;
	localparam int unsigned ADDR_W         = 5;
	localparam int unsigned DATA_W         = 32;
	localparam int unsigned IN_TDATA_W     = 16;
	localparam int unsigned OUT_TDATA_W    = 24;

	// register map, index into the config space (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_LONG_PRESS  = 3'd0,
		REG_RAMP_STEP   = 3'd1,
		REG_REV_TIMEOUT = 3'd2,
		REG_LOW_THR     = 3'd3,
		REG_CRIT_THR    = 3'd4,
		REG_LOWBATT_DLY = 3'd5,
		REG_GREEN_THR   = 3'd6,
		REG_YELLOW_THR  = 3'd7
	} reg_idx_t;

	// battery color codes
	localparam logic [COLOR_W-1:0] COLOR_OFF    = 2'd0;
	localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd1;
	localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd2;
	localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd3;

	// register reset values
	localparam logic [7:0] LONG_PRESS_RST  = 8'd21;
	localparam logic [4:0] RAMP_STEP_RST   = 5'd2;
	localparam logic [7:0] REV_TIMEOUT_RST = 8'd64;
	localparam logic [7:0] LOW_THR_RST     = 8'd124;
	localparam logic [7:0] CRIT_THR_RST    = 8'd114;
	localparam logic [7:0] LOWBATT_DLY_RST = 8'd188;
	localparam logic [7:0] GREEN_THR_RST   = 8'd156;
	localparam logic [7:0] YELLOW_THR_RST  = 8'd142;

	localparam logic [CNT_W-1:0]  CNT_MAX  = 8'hFF;
	localparam logic [HIST_W-1:0] HIST_IDLE = 4'b0000;

	typedef struct packed {
		logic [7:0] long_press;
		logic [4:0] ramp_step;
		logic [7:0] rev_timeout;
		logic [7:0] low_thr;
		logic [7:0] crit_thr;
		logic [7:0] lowbatt_dly;
		logic [7:0] green_thr;
		logic [7:0] yellow_thr;
	} cfg_t;

	typedef struct packed {
		logic [HIST_W-1:0]  hist;
		logic [CNT_W-1:0]   press;
		logic [CNT_W-1:0]   on;
		logic [CNT_W-1:0]   click_gap;
		logic [LVL_W-1:0]   saved;
		logic [LVL_W-1:0]   mode;
		logic               ramp_up;
		logic [CNT_W-1:0]   lowbatt;
		logic [COLOR_W-1:0] color;
	} state_t;

	typedef struct packed {
		logic [LVL_W-1:0]   level_index;
		logic [7:0]         pwm_duty;
		logic [7:0]         pwm_period;
		logic [COLOR_W-1:0] battery_color;
	} result_t;

	localparam logic [7:0] DUTY_ROM [64] = '{
		8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3,
		8'd3, 8'd4, 8'd4, 8'd5, 8'd5, 8'd6, 8'd6, 8'd7,
		8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
		8'd16, 8'd17, 8'd19, 8'd21, 8'd23, 8'd25, 8'd27, 8'd30,
		8'd33, 8'd36, 8'd39, 8'd43, 8'd47, 8'd52, 8'd56, 8'd62,
		8'd68, 8'd74, 8'd81, 8'd89, 8'd97, 8'd106, 8'd116, 8'd127,
		8'd139, 8'd153, 8'd167, 8'd183, 8'd200, 8'd219, 8'd239, 8'd255
	};

	localparam logic [7:0] PERIOD_ROM [64] = '{
		8'd255, 8'd255, 8'd208, 8'd187, 8'd169, 8'd154, 8'd139, 8'd125,
		8'd111, 8'd230, 8'd200, 8'd181, 8'd164, 8'd149, 8'd215, 8'd193,
		8'd176, 8'd223, 8'd200, 8'd243, 8'd212, 8'd246, 8'd215, 8'd234,
		8'd212, 8'd222, 8'd230, 8'd235, 8'd237, 8'd237, 8'd235, 8'd232,
		8'd245, 8'd237, 8'd243, 8'd247, 8'd247, 8'd246, 8'd243, 8'd247,
		8'd249, 8'd248, 8'd246, 8'd248, 8'd248, 8'd252, 8'd248, 8'd251,
		8'd252, 8'd251, 8'd251, 8'd252, 8'd251, 8'd251, 8'd251, 8'd252,
		8'd252, 8'd254, 8'd253, 8'd253, 8'd253, 8'd254, 8'd253, 8'd255
	};

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
		sat_inc = (x == CNT_MAX) ? x : x + 8'd1;
	endfunction

endpackage

@@ rtl/ssrc_cfg.sv @@
// configuration register file with apb-style access
// depends on ssrc_pkg

module ssrc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssrc_pkg::ADDR_W-1:0] paddr,
	input  logic [ssrc_pkg::DATA_W-1:0] pwdata,
	output logic [ssrc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output ssrc_pkg::cfg_t              cfg
);
	import ssrc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press  <= LONG_PRESS_RST;
			cfg_q.ramp_step   <= RAMP_STEP_RST;
			cfg_q.rev_timeout <= REV_TIMEOUT_RST;
			cfg_q.low_thr     <= LOW_THR_RST;
			cfg_q.crit_thr    <= CRIT_THR_RST;
			cfg_q.lowbatt_dly <= LOWBATT_DLY_RST;
			cfg_q.green_thr   <= GREEN_THR_RST;
			cfg_q.yellow_thr  <= YELLOW_THR_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_LONG_PRESS:  cfg_q.long_press  <= pwdata[7:0];
				REG_RAMP_STEP:   cfg_q.ramp_step   <= pwdata[4:0];
				REG_REV_TIMEOUT: cfg_q.rev_timeout <= pwdata[7:0];
				REG_LOW_THR:     cfg_q.low_thr     <= pwdata[7:0];
				REG_CRIT_THR:    cfg_q.crit_thr    <= pwdata[7:0];
				REG_LOWBATT_DLY: cfg_q.lowbatt_dly <= pwdata[7:0];
				REG_GREEN_THR:   cfg_q.green_thr   <= pwdata[7:0];
				REG_YELLOW_THR:  cfg_q.yellow_thr  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_LONG_PRESS:  prdata = {24'd0, cfg_q.long_press};
			REG_RAMP_STEP:   prdata = {27'd0, cfg_q.ramp_step};
			REG_REV_TIMEOUT: prdata = {24'd0, cfg_q.rev_timeout};
			REG_LOW_THR:     prdata = {24'd0, cfg_q.low_thr};
			REG_CRIT_THR:    prdata = {24'd0, cfg_q.crit_thr};
			REG_LOWBATT_DLY: prdata = {24'd0, cfg_q.lowbatt_dly};
			REG_GREEN_THR:   prdata = {24'd0, cfg_q.green_thr};
			REG_YELLOW_THR:  prdata = {24'd0, cfg_q.yellow_thr};
			default:         prdata = '0;
		endcase
	end

endmodule

@@ rtl/ssrc_step.sv @@
// per-tick next-state and result logic: debounce, press timing, ramp, low battery
// depends on ssrc_pkg

module ssrc_step #(
	parameter int unsigned NUM_LEVELS = ssrc_pkg::NUM_LEVELS_DEF
) (
	input  ssrc_pkg::cfg_t    cfg,
	input  ssrc_pkg::state_t  cur,
	input  logic              switch_low,
	input  logic              sample_ready,
	input  logic [7:0]        battery_sample,
	output ssrc_pkg::state_t  nxt,
	output ssrc_pkg::result_t res
);
	import ssrc_pkg::*;

	localparam logic [LVL_W-1:0] MAX_LVL  = LVL_W'(NUM_LEVELS - 1);
	localparam logic [LVL_W-1:0] STEP_LVL = LVL_W'(NUM_LEVELS / 8);
	localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

	function automatic logic [LVL_W-1:0] ramp_level(input logic [LVL_W-1:0] m,
			input logic up);
		logic [LVL_W-1:0] r;
		if (up) begin
			r = (m >= MAX_LVL) ? MAX_LVL : m + LVL_ONE;
		end else begin
			r = (m <= LVL_ONE) ? LVL_ONE : m - LVL_ONE;
		end
		ramp_level = r;
	endfunction

	function automatic logic flip_dir(input logic [LVL_W-1:0] m, input logic up);
		logic r;
		r = ~up;
		if (m <= LVL_ONE) r = 1'b1;
		if (m >= MAX_LVL) r = 1'b0;
		flip_dir = r;
	endfunction

	function automatic logic [LVL_W-1:0] step_down(input logic [LVL_W-1:0] m);
		logic [LVL_W-1:0] r;
		if (m == LVL_ONE) begin
			r = '0;
		end else if (m <= STEP_LVL) begin
			r = LVL_ONE;
		end else begin
			r = m - STEP_LVL;
		end
		step_down = r;
	endfunction

	logic [8:0]       lp_plus1;
	logic [8:0]       lp_plus_step;
	logic [CNT_W-1:0] press_inc;
	logic [7:0]       thr;

	assign lp_plus1     = {1'b0, cfg.long_press} + 9'd1;
	assign lp_plus_step = {1'b0, cfg.long_press} + {4'd0, cfg.ramp_step};
	assign press_inc    = sat_inc(cur.press);

	always_comb begin
		nxt = cur;
		thr = cfg.low_thr;
		// light off keeps the release counters at zero
		if (cur.mode == '0) begin
			nxt.on        = '0;
			nxt.click_gap = '0;
		end
		nxt.hist = {cur.hist[HIST_W-2:0], switch_low};

		if (nxt.hist != HIST_IDLE) begin
			// switch held
			nxt.on      = '0;
			nxt.lowbatt = '0;
			nxt.press   = press_inc;
			if ({1'b0, press_inc} == lp_plus1) begin
				nxt.click_gap = CNT_MAX;
				nxt.mode      = ramp_level(cur.mode, cur.ramp_up);
			end
			if ({1'b0, press_inc} == lp_plus_step) nxt.press = cfg.long_press;
		end else begin
			// switch released
			if (cur.mode != '0) begin
				nxt.on        = sat_inc(cur.on);
				nxt.click_gap = sat_inc(cur.click_gap);
			end
			if (cur.press != '0 && cur.press < cfg.long_press) begin
				// short press
				if (cur.mode == '0) begin
					nxt.mode      = cur.saved;
					nxt.on        = CNT_MAX;
					nxt.click_gap = '0;
					nxt.ramp_up   = flip_dir(cur.saved, cur.ramp_up);
				end else if (nxt.click_gap < cfg.long_press && cur.mode < MAX_LVL) begin
					nxt.mode    = MAX_LVL;
					nxt.ramp_up = flip_dir(MAX_LVL, cur.ramp_up);
				end else begin
					nxt.saved = cur.mode;
					nxt.mode  = '0;
				end
			end else if (cur.press != '0) begin
				// end of a long hold
				nxt.ramp_up = flip_dir(cur.mode, cur.ramp_up);
			end else begin
				if (nxt.on == cfg.rev_timeout) nxt.ramp_up = flip_dir(cur.mode, cur.ramp_up);
				if (cur.mode != '0) begin
					thr = (cur.mode == LVL_ONE) ? cfg.crit_thr : cfg.low_thr;
					if (sample_ready) begin
						nxt.lowbatt = (battery_sample < thr) ? sat_inc(cur.lowbatt) : '0;
						if (battery_sample > cfg.green_thr) begin
							nxt.color = COLOR_GREEN;
						end else if (battery_sample > cfg.yellow_thr) begin
							nxt.color = COLOR_YELLOW;
						end else begin
							nxt.color = COLOR_RED;
						end
					end
					if (nxt.lowbatt >= cfg.lowbatt_dly) begin
						nxt.mode    = step_down(cur.mode);
						nxt.lowbatt = '0;
					end
				end
			end
			nxt.press = '0;
		end

		if (nxt.mode == '0) nxt.color = COLOR_OFF;

		res.level_index   = nxt.mode;
		res.pwm_duty      = DUTY_ROM[nxt.mode];
		res.pwm_period    = PERIOD_ROM[nxt.mode];
		res.battery_color = nxt.color;
	end

endmodule

@@ rtl/single_switch_ramp_controller.sv @@
// single switch ramp controller: one tick in, one level/duty/period/color result out
// path: input register, then result register, from input transfer to result
// throughput: one tick per cycle while m_tready does not stall the result stream; the tick update is a
// single combinational pass between the input register and the state/result registers
// reset: arst_n asynchronous active low; light off, level memory 1, ramp upward,
// config registers at their defaults
// depends on ssrc_pkg, ssrc_cfg, ssrc_step

module single_switch_ramp_controller #(
	parameter int unsigned NUM_LEVELS = ssrc_pkg::NUM_LEVELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// tick input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [0] switch_low, [8:1] battery_sample, [15:9] zero
	input  logic [ssrc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [0] sample_ready
	input  logic                             s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [5:0] level_index, [13:6] pwm_duty, [21:14] pwm_period, [23:22] battery_color
	output logic [ssrc_pkg::OUT_TDATA_W-1:0] m_tdata,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ssrc_pkg::ADDR_W-1:0]      paddr,
	input  logic [ssrc_pkg::DATA_W-1:0]      pwdata,
	output logic [ssrc_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import ssrc_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	result_t res_q;

	// input register stage
	logic       valid_s1;
	logic       switch_s1;
	logic       ready_s1;
	logic [7:0] sample_s1;

	logic out_valid_q;
	logic advance;   // stage 1 item may move into the result register
	logic in_xfer;

	assign advance  = ~out_valid_q | m_tready;
	assign s_tready = ~valid_s1 | advance;
	assign in_xfer  = s_tvalid & s_tready;

	ssrc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssrc_step #(
		.NUM_LEVELS (NUM_LEVELS)
	) u_step (
		.cfg            (cfg),
		.cur            (state_q),
		.switch_low     (switch_s1),
		.sample_ready   (ready_s1),
		.battery_sample (sample_s1),
		.nxt            (state_nxt),
		.res            (res)
	);

	// control: stage valid, result valid and the tick state itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			out_valid_q       <= 1'b0;
			state_q.hist      <= '0;
			state_q.press     <= '0;
			state_q.on        <= '0;
			state_q.click_gap <= '0;
			state_q.saved     <= LVL_W'(1);
			state_q.mode      <= '0;
			state_q.ramp_up   <= 1'b1;
			state_q.lowbatt   <= '0;
			state_q.color     <= COLOR_OFF;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			// state moves exactly once per tick, when the tick reaches the result register
			if (valid_s1 && advance) begin
				state_q <= state_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			switch_s1 <= s_tdata[0];
			sample_s1 <= s_tdata[8:1];
			ready_s1  <= s_tuser;
		end
		if (valid_s1 && advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.battery_color, res_q.pwm_period, res_q.pwm_duty,
		res_q.level_index};

endmodule
